// ----- rtl/core/stdp_pkg.sv -----
// Shared types and constants for the trace-based weight update unit.
package stdp_pkg;

    typedef enum logic [1:0] {
        KIND_CONNECT = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_READ    = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_GAIN_POT  = 3'd0,
        CFG_GAIN_DEP  = 3'd1,
        CFG_W_FLOOR   = 3'd2,
        CFG_W_CEIL    = 3'd3,
        CFG_DECAY_PRE = 3'd4,
        CFG_DECAY_PST = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACE,
        ST_SYN_RD,
        ST_SYN_WAIT,
        ST_SYN_CALC,
        ST_SYN_WB,
        ST_READ_WAIT,
        ST_RESULT
    } t_state;

    localparam int MASK_BITS = 32;

endpackage

// ----- rtl/core/stdp_weight_calc.sv -----
// Weight update datapath: two gain products, rounding and clamping.
module stdp_weight_calc #(
    parameter int TRACE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [15:0]            i_gain_pot,
    input  logic [15:0]            i_gain_dep,
    input  logic [15:0]            i_floor,
    input  logic [15:0]            i_ceil,
    input  logic [TRACE_BITS-1:0]  i_pre_trace,
    input  logic [TRACE_BITS-1:0]  i_post_trace,
    input  logic                   i_do_pot,
    input  logic                   i_do_dep,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    output logic [WEIGHT_BITS-1:0] o_weight
);
    import stdp_pkg::*;

    localparam int PB = 16 + TRACE_BITS;
    localparam int SH = 16 + (TRACE_BITS - 5) - (WEIGHT_BITS - 1);
    localparam int XB = PB + WEIGHT_BITS + 4;

    logic [PB-1:0] r_prod_pot, r_prod_dep;
    logic          r_do_pot, r_do_dep;
    logic [WEIGHT_BITS-1:0] r_w;

    always_ff @(posedge i_clk) begin
        r_prod_pot <= PB'(i_gain_pot) * PB'(i_pre_trace);
        r_prod_dep <= PB'(i_gain_dep) * PB'(i_post_trace);
        r_do_pot   <= i_do_pot;
        r_do_dep   <= i_do_dep;
        r_w        <= i_weight;
    end

    function automatic logic signed [XB-1:0] scale(input logic [PB-1:0] p);
        logic [XB-1:0] e;
        e = XB'(p);
        if (SH > 0) begin
            e = (e + (XB'(1) << (SH - 1))) >> SH;
        end else if (SH < 0) begin
            e = e << (-SH);
        end
        return signed'(e);
    endfunction

    logic signed [XB-1:0] sum;
    always_comb begin
        sum = signed'(XB'(r_w));
        if (r_do_pot) sum = sum + scale(r_prod_pot);
        if (r_do_dep) sum = sum - scale(r_prod_dep);
        if (sum < signed'(XB'(i_floor))) sum = signed'(XB'(i_floor));
        if (sum > signed'(XB'(i_ceil)))  sum = signed'(XB'(i_ceil));
        o_weight = sum[WEIGHT_BITS-1:0];
    end
endmodule

// ----- rtl/core/stdp_trace_bank.sv -----
// Presynaptic and postsynaptic trace stores with decay and spike bump.
module stdp_trace_bank #(
    parameter int NEURONS    = 32,
    parameter int TRACE_BITS = 16,
    parameter int NB         = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_upd,
    input  logic [NB-1:0]         i_upd_idx,
    input  logic                  i_upd_spike,
    input  logic [15:0]           i_decay_pre,
    input  logic [15:0]           i_decay_post,
    input  logic [NB-1:0]         i_rd_pre_idx,
    input  logic [NB-1:0]         i_rd_post_idx,
    output logic [TRACE_BITS-1:0] o_pre,
    output logic [TRACE_BITS-1:0] o_post
);
    import stdp_pkg::*;

    localparam int PB = TRACE_BITS + 17;
    localparam logic [TRACE_BITS:0] ONE = (TRACE_BITS+1)'(1) << (TRACE_BITS - 5);
    localparam logic [TRACE_BITS:0] TMAX = {1'b0, {TRACE_BITS{1'b1}}};

    // Traces are few, so each entry is a flip-flop word cleared by reset.
    logic [TRACE_BITS-1:0] r_pre [NEURONS];
    logic [TRACE_BITS-1:0] r_post[NEURONS];

    function automatic logic [TRACE_BITS-1:0] step(input logic [TRACE_BITS-1:0] t,
                                                    input logic [15:0] f,
                                                    input logic sp);
        logic [PB-1:0] p;
        logic [TRACE_BITS:0] v;
        p = PB'(t) * PB'(f) + PB'(32768);
        v = (TRACE_BITS+1)'(p >> 16);
        if (sp) v = v + ONE;
        if (v > TMAX) v = TMAX;
        return v[TRACE_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < NEURONS; n++) begin
                r_pre[n]  <= '0;
                r_post[n] <= '0;
            end
        end else if (i_upd) begin
            r_pre[i_upd_idx]  <= step(r_pre[i_upd_idx], i_decay_pre, i_upd_spike);
            r_post[i_upd_idx] <= step(r_post[i_upd_idx], i_decay_post, i_upd_spike);
        end
    end

    always_ff @(posedge i_clk) begin
        o_pre  <= r_pre[i_rd_pre_idx];
        o_post <= r_post[i_rd_post_idx];
    end
endmodule

// ----- rtl/core/stdp_trace_weight_update_unit.sv -----
// Top level of the trace-based STDP weight update unit.
// Every input request gives one result request. A tick decays all NEURONS
// traces, one trace per cycle, then takes each connected synapse through the
// read, wait, multiply and write-back sequence of the single-port synapse
// memory. The synapse memory needs no clearing pass: only entries below the
// fill count are ever used.
module stdp_trace_weight_update_unit #(
    parameter int NEURONS     = 32,
    parameter int SYNAPSES    = 256,
    parameter int TRACE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: source_neuron[4:0], target_neuron[9:5],
    // initial_weight[25:10], spike_mask[57:26], synapse_index[65:58].
    input  logic [71:0] s_axis_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: accepted[0], synapses_used[9:1], weight_value[25:10].
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import stdp_pkg::*;

    localparam int NB = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int SB = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
    localparam int CB = $clog2(SYNAPSES + 1);
    localparam int ENT = 2*NB + WEIGHT_BITS;

    logic [15:0] r_gain_pot, r_gain_dep, r_floor, r_ceil, r_dec_pre, r_dec_post;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_pot <= 16'd328; r_gain_dep <= 16'd344;
            r_floor <= 16'd0; r_ceil <= 16'd32768;
            r_dec_pre <= 16'd62339; r_dec_post <= 16'd62339;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_POT:  r_gain_pot <= i_cfg_data;
                CFG_GAIN_DEP:  r_gain_dep <= i_cfg_data;
                CFG_W_FLOOR:   r_floor    <= i_cfg_data;
                CFG_W_CEIL:    r_ceil     <= i_cfg_data;
                CFG_DECAY_PRE: r_dec_pre  <= i_cfg_data;
                CFG_DECAY_PST: r_dec_post <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [CB-1:0] r_count, r_ptr;
    logic [NB-1:0] r_nidx;
    logic [MASK_BITS-1:0] r_mask;
    logic r_acc, r_out_valid;
    logic [15:0] r_value;

    // Synapse store: one entry holds source, target and weight.
    logic [ENT-1:0] r_mem [SYNAPSES];
    logic [ENT-1:0] r_mem_q;
    logic mem_we;
    logic [SB-1:0] mem_addr;
    logic [ENT-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        r_mem_q <= r_mem[mem_addr];
    end

    wire in_acc = s_axis_tvalid && s_axis_tready;
    wire t_kind in_kind = t_kind'(s_axis_tuser);
    wire [4:0]  in_src = s_axis_tdata[4:0];
    wire [4:0]  in_dst = s_axis_tdata[9:5];
    wire [15:0] in_w0  = s_axis_tdata[25:10];
    wire [7:0]  in_idx = s_axis_tdata[65:58];

    wire [NB-1:0] q_src = r_mem_q[NB-1:0];
    wire [NB-1:0] q_dst = r_mem_q[2*NB-1:NB];
    wire [WEIGHT_BITS-1:0] q_w = r_mem_q[ENT-1:2*NB];

    function automatic logic spk(input logic [MASK_BITS-1:0] m, input logic [NB-1:0] n);
        return (32'(n) < 32'(MASK_BITS)) ? m[n[$clog2(MASK_BITS)-1:0]] : 1'b0;
    endfunction

    logic [TRACE_BITS-1:0] pre_t, post_t;
    stdp_trace_bank #(.NEURONS(NEURONS), .TRACE_BITS(TRACE_BITS), .NB(NB)) u_traces (
        .i_clk, .i_rst_n,
        .i_upd(r_state == ST_TRACE), .i_upd_idx(r_nidx), .i_upd_spike(spk(r_mask, r_nidx)),
        .i_decay_pre(r_dec_pre), .i_decay_post(r_dec_post),
        .i_rd_pre_idx(q_src), .i_rd_post_idx(q_dst),
        .o_pre(pre_t), .o_post(post_t)
    );

    // The memory entry is held in a stage register alongside the trace read.
    logic [ENT-1:0] r_ent;
    always_ff @(posedge i_clk) if (r_state == ST_SYN_WAIT) r_ent <= r_mem_q;
    wire [NB-1:0] e_src = r_ent[NB-1:0];
    wire [NB-1:0] e_dst = r_ent[2*NB-1:NB];

    logic [WEIGHT_BITS-1:0] new_w;
    stdp_weight_calc #(.TRACE_BITS(TRACE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_calc (
        .i_clk, .i_gain_pot(r_gain_pot), .i_gain_dep(r_gain_dep),
        .i_floor(r_floor), .i_ceil(r_ceil),
        .i_pre_trace(pre_t), .i_post_trace(post_t),
        .i_do_pot(spk(r_mask, e_dst)), .i_do_dep(spk(r_mask, e_src)),
        .i_weight(r_ent[ENT-1:2*NB]), .o_weight(new_w)
    );

    // Connect items clamp the initial weight the same way.
    logic [WEIGHT_BITS-1:0] w0c;
    always_comb begin
        logic [16:0] t;
        t = {1'b0, in_w0};
        if (t < {1'b0, r_floor}) t = {1'b0, r_floor};
        if (t > {1'b0, r_ceil})  t = {1'b0, r_ceil};
        w0c = t[WEIGHT_BITS-1:0];
    end

    wire conn_ok = (r_count < CB'(SYNAPSES)) && (32'(in_src) < 32'(NEURONS))
                   && (32'(in_dst) < 32'(NEURONS));
    wire read_ok = (9'(in_idx) < 9'(r_count)) && (32'(in_idx) < 32'(SYNAPSES));

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) begin
                if (in_kind == KIND_TICK) n_state = ST_TRACE;
                else if (in_kind == KIND_READ && read_ok) n_state = ST_READ_WAIT;
                else n_state = ST_RESULT;
            end
            ST_TRACE: if (32'(r_nidx) == NEURONS - 1)
                n_state = (r_count == '0) ? ST_RESULT : ST_SYN_RD;
            ST_SYN_RD:    n_state = ST_SYN_WAIT;
            ST_SYN_WAIT:  n_state = ST_SYN_CALC;
            ST_SYN_CALC:  n_state = ST_SYN_WB;
            ST_SYN_WB:    n_state = ST_RESULT;
            ST_READ_WAIT: n_state = ST_RESULT;
            ST_RESULT:    n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
        if (r_state == ST_SYN_WB && r_ptr + 1'b1 < r_count) n_state = ST_SYN_RD;
    end

    always_comb begin
        mem_we = 1'b0; mem_addr = r_ptr[SB-1:0]; mem_wd = {new_w, e_dst, e_src};
        unique case (r_state)
            ST_IDLE: begin
                if (in_kind == KIND_READ) mem_addr = in_idx[SB-1:0];
                else mem_addr = r_count[SB-1:0];
                if (in_acc && in_kind == KIND_CONNECT && conn_ok) begin
                    mem_we = 1'b1;
                    mem_wd = {w0c, in_dst[NB-1:0], in_src[NB-1:0]};
                end
            end
            // The weight datapath has a product register, so the new weight
            // is ready in the cycle after the traces are presented.
            ST_SYN_WB: mem_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_count <= '0; r_out_valid <= 1'b0;
            r_ptr <= '0; r_nidx <= '0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            if (r_state == ST_RESULT) r_out_valid <= 1'b1;
            unique case (r_state)
                ST_IDLE: if (in_acc) begin
                    r_mask <= s_axis_tdata[57:26];
                    r_nidx <= '0; r_ptr <= '0; r_value <= '0;
                    r_acc <= (in_kind == KIND_TICK) ||
                             (in_kind == KIND_CONNECT && conn_ok) ||
                             (in_kind == KIND_READ && read_ok);
                    if (in_kind == KIND_CONNECT && conn_ok) r_count <= r_count + 1'b1;
                end
                ST_TRACE:     r_nidx <= r_nidx + 1'b1;
                ST_SYN_WB:    r_ptr <= r_ptr + 1'b1;
                ST_READ_WAIT: r_value <= 16'(q_w);
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {6'd0, r_value, 9'(r_count), r_acc};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SYNAPSES) else $error("count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
`endif
endmodule

// ----- sim/stdp_weight_checker.sv -----
// Checker that predicts and compares every result of the STDP weight update unit.
`timescale 1ns / 1ps

module stdp_weight_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import stdp_pkg::*;

    localparam int NEURONS = 32;
    localparam int SYNAPSES = 256;

    // Members from the highest bit down, so accepted sits in bit 0.
    typedef struct packed {
        logic [15:0] weight_value;
        logic [8:0]  synapses_used;
        logic        accepted;
    } t_outcome;

    logic [15:0] gain_pot, gain_dep, w_floor, w_ceil, decay_pre, decay_pst;
    logic [15:0] pre_tr [NEURONS];
    logic [15:0] pst_tr [NEURONS];
    logic [15:0] syn_w [SYNAPSES];
    logic [4:0]  syn_src [SYNAPSES];
    logic [4:0]  syn_dst [SYNAPSES];
    int          syn_cnt;
    t_outcome    outcome_queue [$];

    function automatic logic [15:0] clamp_w(longint w);
        if (w < longint'(w_floor)) w = longint'(w_floor);
        if (w > longint'(w_ceil)) w = longint'(w_ceil);
        return w[15:0];
    endfunction

    function automatic logic [15:0] decay(logic [15:0] t, logic [15:0] f);
        logic [32:0] p;
        p = t * f + 33'd32768;
        return p[31:16];
    endfunction

    function automatic logic [15:0] bump(logic [15:0] t);
        logic [16:0] v;
        v = t + 17'd2048;
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    // Gain (Q0.16) times trace (Q5.11) down to Q1.15: shift by 12, round half up.
    function automatic longint change(logic [15:0] g, logic [15:0] t);
        logic [32:0] p;
        p = g * t + 33'd2048;
        return longint'(p >> 12);
    endfunction

    function automatic t_outcome predict_outcome(t_kind kind, logic [71:0] d);
        t_outcome r;
        logic [4:0]  src, dst;
        logic [31:0] mask;
        logic [7:0]  idx;
        longint      w;
        src = d[4:0];
        dst = d[9:5];
        mask = d[57:26];
        idx = d[65:58];
        r = '0;
        case (kind)
            KIND_CONNECT: begin
                if (syn_cnt < SYNAPSES) begin
                    syn_src[syn_cnt] = src;
                    syn_dst[syn_cnt] = dst;
                    syn_w[syn_cnt] = clamp_w(longint'(d[25:10]));
                    syn_cnt++;
                    r.accepted = 1'b1;
                end
            end
            KIND_TICK: begin
                for (int n = 0; n < NEURONS; n++) begin
                    pre_tr[n] = decay(pre_tr[n], decay_pre);
                    pst_tr[n] = decay(pst_tr[n], decay_pst);
                    if (mask[n]) begin
                        pre_tr[n] = bump(pre_tr[n]);
                        pst_tr[n] = bump(pst_tr[n]);
                    end
                end
                for (int s = 0; s < syn_cnt; s++) begin
                    w = longint'(syn_w[s]);
                    if (mask[syn_dst[s]]) w += change(gain_pot, pre_tr[syn_src[s]]);
                    if (mask[syn_src[s]]) w -= change(gain_dep, pst_tr[syn_dst[s]]);
                    syn_w[s] = clamp_w(w);
                end
                r.accepted = 1'b1;
            end
            KIND_READ: begin
                if (idx < syn_cnt) begin
                    r.weight_value = syn_w[idx];
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.synapses_used = syn_cnt[8:0];
        return r;
    endfunction

    assign o_pending = outcome_queue.size();

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            gain_pot = 16'd328;
            gain_dep = 16'd344;
            w_floor = 16'd0;
            w_ceil = 16'd32768;
            decay_pre = 16'd62339;
            decay_pst = 16'd62339;
            for (int n = 0; n < NEURONS; n++) begin
                pre_tr[n] = '0;
                pst_tr[n] = '0;
            end
            syn_cnt = 0;
            outcome_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_POT:  gain_pot = i_cfg_data;
                    CFG_GAIN_DEP:  gain_dep = i_cfg_data;
                    CFG_W_FLOOR:   w_floor = i_cfg_data;
                    CFG_W_CEIL:    w_ceil = i_cfg_data;
                    CFG_DECAY_PRE: decay_pre = i_cfg_data;
                    CFG_DECAY_PST: decay_pst = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[25:0];
                if (outcome_queue.size() == 0) begin
                    $error("result with none expected: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = outcome_queue.pop_front();
                    if (got.accepted !== want.accepted ||
                        got.synapses_used !== want.synapses_used ||
                        got.weight_value !== want.weight_value) begin
                        if (got.accepted !== want.accepted)
                            $error("accepted: expected %0d, got %0d",
                                   want.accepted, got.accepted);
                        if (got.synapses_used !== want.synapses_used)
                            $error("synapses_used: expected %0d, got %0d",
                                   want.synapses_used, got.synapses_used);
                        if (got.weight_value !== want.weight_value)
                            $error("weight_value: expected %0d, got %0d",
                                   want.weight_value, got.weight_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                outcome_queue.push_back(predict_outcome(t_kind'(s_axis_tuser), s_axis_tdata));
        end
    end

endmodule

// ----- sim/stdp_trace_weight_update_unit_tb.sv -----
// Stimulus and verdict for the STDP trace weight update unit.
`timescale 1ns / 1ps

module stdp_trace_weight_update_unit_tb;
    import stdp_pkg::*;

    // The watchdog allows several full-table ticks plus the longest output stall.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 1200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_mode = 0;

    always #5 i_clk = ~i_clk;

    stdp_trace_weight_update_unit dut (.*);

    stdp_weight_checker checker_i (.*, .o_fail_count(fail_count), .o_pending(pending));

    // The receiver alternates between always-ready stretches, light stalls
    // and long stalls, switching mode at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: cycles in which no request of any kind is accepted.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    int burst_left = 0;

    // Sends one request; the sender works in bursts separated by random gaps.
    task automatic send_item(t_kind kind, logic [4:0] src, logic [4:0] dst,
                             logic [15:0] w0, logic [31:0] mask, logic [7:0] idx);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, idx, mask, w0, dst, src};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_mask(output logic [31:0] m);
        case ($urandom_range(0, 3))
            0: m = $urandom();
            1: m = 32'd1 << $urandom_range(0, 31);
            2: m = $urandom() & $urandom() & $urandom();
            default: m = '0;
        endcase
    endtask

    task automatic random_item();
        logic [31:0] m;
        int pick;
        pick = $urandom_range(0, 99);
        random_mask(m);
        if (pick < 35)
            send_item(KIND_CONNECT, 5'($urandom()), 5'($urandom()),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
                      $urandom(), 8'($urandom()));
        else if (pick < 65)
            send_item(KIND_TICK, 5'($urandom()), 5'($urandom()), 16'($urandom()), m,
                      8'($urandom()));
        else if (pick < 97)
            send_item(KIND_READ, 5'($urandom()), 5'($urandom()), 16'($urandom()), $urandom(),
                      8'($urandom_range(0, 255)));
        else
            send_item(KIND_UNUSED, 5'($urandom()), 5'($urandom()), 16'($urandom()), $urandom(),
                      8'($urandom()));
    endtask

    // Random settings for every register; the extremes come up now and then.
    task automatic random_settings();
        logic [15:0] lo, hi;
        lo = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 16000));
        hi = ($urandom_range(0, 3) == 0) ? 16'd32768 : 16'($urandom_range(16000, 32768));
        if ($urandom_range(0, 7) == 0) {lo, hi} = {hi, lo};
        write_reg(CFG_GAIN_POT, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8000)));
        write_reg(CFG_GAIN_DEP, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8000)));
        write_reg(CFG_W_FLOOR, lo);
        write_reg(CFG_W_CEIL, hi);
        write_reg(CFG_DECAY_PRE, ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom()));
        write_reg(CFG_DECAY_PST, ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom()));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a read of the empty table, unused kind, connects at the weight extremes.
        send_item(KIND_READ, 5'd0, 5'd0, 16'd0, 32'd0, 8'd0);
        send_item(KIND_UNUSED, 5'h1F, 5'h1F, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(KIND_CONNECT, 5'd0, 5'd31, 16'd0, 32'd0, 8'd0);
        send_item(KIND_CONNECT, 5'd31, 5'd0, 16'd32768, 32'd0, 8'd0);
        send_item(KIND_CONNECT, 5'd3, 5'd3, 16'hFFFF, 32'd0, 8'd0);
        send_item(KIND_CONNECT, 5'd1, 5'd2, 16'd16384, 32'd0, 8'd0);
        // Simultaneous spikes, then repeated all-ones ticks to build up the traces.
        send_item(KIND_TICK, 5'd0, 5'd0, 16'd0, 32'h8000_0009, 8'd0);
        repeat (20) send_item(KIND_TICK, 5'd0, 5'd0, 16'd0, 32'hFFFF_FFFF, 8'd0);
        send_item(KIND_TICK, 5'd0, 5'd0, 16'd0, 32'h0000_0000, 8'd0);
        for (int i = 0; i < 5; i++) send_item(KIND_READ, 5'd0, 5'd0, 16'd0, 32'd0, 8'(i));
        send_item(KIND_READ, 5'd0, 5'd0, 16'd0, 32'd0, 8'hFF);
        drain_results();

        // Floor above ceiling, zero and maximum gains and decays.
        write_reg(CFG_W_FLOOR, 16'd30000);
        write_reg(CFG_W_CEIL, 16'd1000);
        write_reg(CFG_GAIN_POT, 16'hFFFF);
        write_reg(CFG_GAIN_DEP, 16'd0);
        write_reg(CFG_DECAY_PRE, 16'hFFFF);
        write_reg(CFG_DECAY_PST, 16'd0);
        send_item(KIND_CONNECT, 5'd4, 5'd5, 16'd20000, 32'd0, 8'd0);
        send_item(KIND_TICK, 5'd0, 5'd0, 16'd0, 32'h0000_0030, 8'd0);
        send_item(KIND_READ, 5'd0, 5'd0, 16'd0, 32'd0, 8'd4);
        drain_results();

        // Random phases; the table fills part way through and later
        // connects bounce off it.
        for (int phase = 0; phase < 8; phase++) begin
            random_settings();
            repeat (100) random_item();
            // Sender holds off until every result is back.
            drain_results();
        end

        // Fill the table for certain and probe the full condition.
        repeat (260) send_item(KIND_CONNECT, 5'($urandom()), 5'($urandom()),
                               16'($urandom_range(0, 32768)), 32'd0, 8'd0);
        send_item(KIND_TICK, 5'd0, 5'd0, 16'd0, $urandom(), 8'd0);
        send_item(KIND_READ, 5'd0, 5'd0, 16'd0, 32'd0, 8'd255);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
